// ===== hdl/pwmcap_pkg.sv =====
// Shared constants for the PWM frequency and duty capture core.
`default_nettype none
package pwmcap_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF  = 32;

  localparam int TICK_W    = 9;
  localparam int FREQ_W    = 20;
  localparam int DUTY_W    = 7;
  localparam int TSTAMP_W  = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CNT_W     = 5;

  localparam logic [FREQ_W-1:0] MICROS_PER_SECOND = 20'd1000000;
  localparam logic [TICK_W-1:0] PERCENT_SCALE     = 9'd100;
  localparam logic [TICK_W-1:0] TICK_RESET        = 9'd1;

  localparam logic [CFG_ADDR_W-1:0] REG_TICK_TIME = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 1'b1;

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/pwm_frequency_duty_capture_core.sv =====
// Top level of the PWM frequency and duty capture core with a bit-serial multiply and divide.
// A read item's result is registered and shown in the cycle after acceptance; a first rising
// edge stores the count, a falling edge runs a 9-step shift-add multiply by the tick time.
// A second rising edge runs the low-time multiply, frequency division (skipped, with the error
// flag set, on a zero period), percent scaling multiply and duty division on one shared unit.
// Throughput: one item at a time; the input stalls while the serial unit is busy.
// Reset (rst_n, synchronous, active low) clears results, phase and mode, and sets tick time to 1.
`default_nettype none
module pwm_frequency_duty_capture_core #(
  parameter int COUNT_WIDTH = pwmcap_pkg::COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH  = pwmcap_pkg::TIME_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [pwmcap_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pwmcap_pkg::TICK_W-1:0]     cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // timer_count[15:0]
  input  wire logic        in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata  // frequency_hz[19:0], duty_percent[26:20], period_error[27]
);

  localparam int MW   = TIME_WIDTH + pwmcap_pkg::TICK_W;
  localparam int FW   = pwmcap_pkg::FREQ_W;
  localparam int DW   = pwmcap_pkg::DUTY_W;
  localparam int TW   = pwmcap_pkg::TICK_W;
  localparam int OUTW = FW + DW + 1;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;
  typedef enum logic [2:0] {OP_HIGH, OP_LOW, OP_SCALE, OP_FREQ, OP_DUTY} op_t;
  typedef enum logic [1:0] {PH_FIRST = 2'd0, PH_FALL = 2'd1, PH_SECOND = 2'd2} phase_t;

  state_t                 state_r;
  op_t                    op_r;
  phase_t                 phase_r;
  logic [COUNT_WIDTH-1:0] last_r;
  logic [TIME_WIDTH-1:0]  high_r;
  logic [TIME_WIDTH-1:0]  period_r;
  logic [FW-1:0]          freq_r;
  logic [DW-1:0]          duty_r;
  logic                   err_r;
  logic [TW-1:0]          tick_r;
  logic                   mode_r;
  logic [TIME_WIDTH-1:0]  mcand_r;
  logic [TW-1:0]          mplier_r;
  logic [MW-1:0]          acc_r;
  logic [TIME_WIDTH-1:0]  rem_r;
  logic [FW-1:0]          dvd_r;
  logic [FW-1:0]          quo_r;
  logic [pwmcap_pkg::CNT_W-1:0] cnt_r;
  logic                   out_tvalid_r;
  logic [OUTW-1:0]        out_data_r;

  logic                   in_fire;
  logic [COUNT_WIDTH-1:0] now_c;
  logic [COUNT_WIDTH-1:0] diff_raw;
  logic [COUNT_WIDTH-1:0] diff_c;
  logic [MW-1:0]          acc_nxt;
  logic [TIME_WIDTH-1:0]  acc_sat;
  logic [TIME_WIDTH:0]    sum_c;
  logic [TIME_WIDTH-1:0]  period_c;
  logic [TIME_WIDTH:0]    rem_sh;
  logic                   rem_ge;
  logic [TIME_WIDTH:0]    rem_sub;
  logic [TIME_WIDTH-1:0]  rem_nxt;

  assign in_tready = (state_r == S_IDLE) &&
                     ((in_tuser == pwmcap_pkg::REQ_EDGE) || !out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(32 - OUTW)'(0), out_data_r};

  assign now_c    = in_tdata[COUNT_WIDTH-1:0];
  assign diff_raw = now_c - last_r;
  assign diff_c   = mode_r ? diff_raw : COUNT_WIDTH'(diff_raw[7:0]);

  assign acc_nxt  = {acc_r[MW-2:0], 1'b0} + (mplier_r[TW-1] ? MW'(mcand_r) : '0);
  assign acc_sat  = (|acc_r[MW-1:TIME_WIDTH]) ? '1 : acc_r[TIME_WIDTH-1:0];
  assign sum_c    = {1'b0, high_r} + {1'b0, acc_sat};
  assign period_c = sum_c[TIME_WIDTH] ? '1 : sum_c[TIME_WIDTH-1:0];

  assign rem_sh  = {rem_r, dvd_r[FW-1]};
  assign rem_ge  = rem_sh >= {1'b0, period_r};
  assign rem_sub = rem_sh - {1'b0, period_r};
  assign rem_nxt = rem_ge ? rem_sub[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_HIGH;
      phase_r      <= PH_FIRST;
      last_r       <= '0;
      high_r       <= '0;
      freq_r       <= '0;
      duty_r       <= '0;
      err_r        <= 1'b0;
      tick_r       <= pwmcap_pkg::TICK_RESET;
      mode_r       <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pwmcap_pkg::REG_TICK_TIME: tick_r <= cfg_wdata;
          pwmcap_pkg::REG_MODE:      mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready &&
          !(in_fire && in_tuser == pwmcap_pkg::REQ_READ)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_tuser == pwmcap_pkg::REQ_READ) begin
              out_data_r   <= {err_r, duty_r, freq_r};
              out_tvalid_r <= 1'b1;
              freq_r       <= '0;
              duty_r       <= '0;
              err_r        <= 1'b0;
            end else begin
              case (phase_r)
                PH_FALL: begin
                  mcand_r  <= TIME_WIDTH'(diff_c);
                  mplier_r <= tick_r;
                  acc_r    <= '0;
                  cnt_r    <= pwmcap_pkg::CNT_W'(TW);
                  op_r     <= OP_HIGH;
                  state_r  <= S_MUL;
                  last_r   <= now_c;
                  phase_r  <= PH_SECOND;
                end
                PH_SECOND: begin
                  mcand_r  <= TIME_WIDTH'(diff_c);
                  mplier_r <= tick_r;
                  acc_r    <= '0;
                  cnt_r    <= pwmcap_pkg::CNT_W'(TW);
                  op_r     <= OP_LOW;
                  state_r  <= S_MUL;
                  phase_r  <= PH_FIRST;
                end
                default: begin
                  last_r  <= now_c;
                  phase_r <= PH_FALL;
                end
              endcase
            end
          end
        end
        S_MUL: begin
          if (cnt_r != '0) begin
            acc_r    <= acc_nxt;
            mplier_r <= {mplier_r[TW-2:0], 1'b0};
            cnt_r    <= cnt_r - 1'b1;
          end else begin
            case (op_r)
              OP_HIGH: begin
                high_r  <= acc_sat;
                state_r <= S_IDLE;
              end
              OP_LOW: begin
                if (period_c == '0) begin
                  err_r   <= 1'b1;
                  state_r <= S_IDLE;
                end else begin
                  period_r <= period_c;
                  rem_r    <= '0;
                  dvd_r    <= pwmcap_pkg::MICROS_PER_SECOND;
                  quo_r    <= '0;
                  cnt_r    <= pwmcap_pkg::CNT_W'(FW);
                  op_r     <= OP_FREQ;
                  state_r  <= S_DIV;
                end
              end
              default: begin
                rem_r   <= acc_r[TIME_WIDTH+DW-1:DW];
                dvd_r   <= {acc_r[DW-1:0], (FW - DW)'(0)};
                quo_r   <= '0;
                cnt_r   <= pwmcap_pkg::CNT_W'(DW);
                op_r    <= OP_DUTY;
                state_r <= S_DIV;
              end
            endcase
          end
        end
        S_DIV: begin
          if (cnt_r != '0) begin
            rem_r <= rem_nxt;
            dvd_r <= {dvd_r[FW-2:0], 1'b0};
            quo_r <= {quo_r[FW-2:0], rem_ge};
            cnt_r <= cnt_r - 1'b1;
          end else if (op_r == OP_FREQ) begin
            freq_r   <= quo_r;
            mcand_r  <= high_r;
            mplier_r <= pwmcap_pkg::PERCENT_SCALE;
            acc_r    <= '0;
            cnt_r    <= pwmcap_pkg::CNT_W'(TW);
            op_r     <= OP_SCALE;
            state_r  <= S_MUL;
          end else begin
            duty_r  <= quo_r[DW-1:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r <= DW'(100))
    else $error("duty above one hundred percent");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < period_r))
    else $error("divider remainder not below the period");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == pwmcap_pkg::REQ_READ) |=>
      (out_tvalid_r && freq_r == '0 && duty_r == '0 && !err_r))
    else $error("read item did not present and clear the results");

  a_second_edge_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == pwmcap_pkg::REQ_EDGE && phase_r == PH_SECOND) |=>
      (state_r == S_MUL && op_r == OP_LOW && !in_tready))
    else $error("second rising edge did not start the low-time multiply");
`endif

endmodule
`default_nettype wire
